FILE: rtl/core/crc_checked_telemetry_frame_parser_top_macros.svh
// assertion macros shared by the frame parser rtl
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef CRC_CHECKED_TELEMETRY_FRAME_PARSER_TOP_MACROS_SVH
`define CRC_CHECKED_TELEMETRY_FRAME_PARSER_TOP_MACROS_SVH

// property holds at every clock edge out of reset
`define CTFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies consequence in the next
`define CTFP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/ctfp_pkg.sv
// types, constants and crc function for the telemetry frame parser
// no dependencies
package ctfp_pkg;

    localparam int FRAME_BYTES = 28;
    localparam int CRC_SPAN    = 26;
    localparam int BODY_FIRST  = 4;
    localparam int BODY_BYTES  = CRC_SPAN - BODY_FIRST;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int Q_DEPTH     = 2;
    localparam int QPTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR2 = POS_W'(1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] CRC_END  = POS_W'(CRC_SPAN);

    typedef enum logic [1:0] {
        CFG_HDR_FIRST  = 2'd0,
        CFG_HDR_SECOND = 2'd1,
        CFG_VERSION    = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_VALID       = 2'd0,
        ST_BAD_VERSION = 2'd1,
        ST_BAD_LENGTH  = 2'd2,
        ST_BAD_CRC     = 2'd3
    } t_frame_status;

    // completed frame as handed from the byte parser to the result stage
    typedef struct packed {
        logic                            crc_ok;
        logic [7:0]                      version;
        logic [7:0]                      length;
        logic [BODY_BYTES-1:0][7:0]      body;
    } t_frame_rec;

    typedef struct packed {
        t_frame_status       status;
        logic [15:0]         sequence_number;
        logic [31:0]         timestamp_millis;
        logic [7:0]          motion_mode;
        logic [7:0]          status_flags;
        logic signed [15:0]  track_acceleration;
        logic signed [15:0]  yaw_rate;
        logic [15:0]         vibration_level;
        logic signed [15:0]  line_offset;
        logic signed [15:0]  left_wheel_speed;
        logic signed [15:0]  right_wheel_speed;
        logic signed [15:0]  turn_amount;
    } t_result;

    // crc-16/ccitt-false, msb first, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/ctfp_front.sv
// byte parser: header hunt, position count, running crc and frame store
// depends on ctfp_pkg and the assertion macro header
`include "crc_checked_telemetry_frame_parser_top_macros.svh"

module ctfp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    input  logic [7:0]            i_hdr_first,
    input  logic [7:0]            i_hdr_second,
    output logic                  o_push,
    output ctfp_pkg::t_frame_rec  o_rec
);
    import ctfp_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_store [FRAME_BYTES];
    logic             store_we;
    logic [POS_W-1:0] store_addr;

    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        o_push     = 1'b0;
        store_we   = 1'b0;
        store_addr = r_pos;
        if (i_valid) begin
            case (r_pos)
                POS_HUNT: begin
                    if (i_byte == i_hdr_first) begin
                        store_we = 1'b1;
                        n_crc    = crc_feed(CRC_INIT, i_byte);
                        n_pos    = POS_HDR2;
                    end
                end
                POS_HDR2: begin
                    if (i_byte == i_hdr_second) begin
                        store_we = 1'b1;
                        n_crc    = crc_feed(r_crc, i_byte);
                        n_pos    = r_pos + 1'b1;
                    end else if (i_byte == i_hdr_first) begin
                        // another first header byte starts over
                        store_we   = 1'b1;
                        store_addr = POS_HUNT;
                        n_crc      = crc_feed(CRC_INIT, i_byte);
                        n_pos      = POS_HDR2;
                    end else begin
                        n_crc = CRC_INIT;
                        n_pos = POS_HUNT;
                    end
                end
                default: begin
                    if (r_pos > LAST_POS) begin
                        n_crc = CRC_INIT;
                        n_pos = POS_HUNT;
                    end else begin
                        store_we = 1'b1;
                        if (r_pos < CRC_END) begin
                            n_crc = crc_feed(r_crc, i_byte);
                        end
                        if (r_pos == LAST_POS) begin
                            o_push = 1'b1;
                            n_crc  = CRC_INIT;
                            n_pos  = POS_HUNT;
                        end else begin
                            n_pos = r_pos + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // record is built from the store plus the crc high byte arriving now
    always_comb begin
        o_rec.crc_ok  = ({i_byte, r_store[CRC_SPAN]} == r_crc);
        o_rec.version = r_store[2];
        o_rec.length  = r_store[3];
        for (int k = 0; k < BODY_BYTES; k++) begin
            o_rec.body[k] = r_store[BODY_FIRST + k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_crc <= CRC_INIT;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_addr] <= i_byte;
        end
    end

    `CTFP_ASSERT(a_pos_range, r_pos <= LAST_POS, "byte position out of frame")
    `CTFP_ASSERT(a_push_at_end, o_push |-> (r_pos == LAST_POS && i_valid), "push off frame end")

endmodule

FILE: rtl/core/ctfp_queue.sv
// short queue of completed frame records between parser and result stage
// depends on ctfp_pkg and the assertion macro header
`include "crc_checked_telemetry_frame_parser_top_macros.svh"

module ctfp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ctfp_pkg::t_frame_rec  i_rec,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output ctfp_pkg::t_frame_rec  o_rec
);
    import ctfp_pkg::*;

    t_frame_rec        r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    `CTFP_ASSERT(a_count_bound, r_count <= QCNT_W'(Q_DEPTH), "queue count over depth")

endmodule

FILE: rtl/core/ctfp_back.sv
// result stage: classifies a frame record, decodes fields, holds the result
// depends on ctfp_pkg and the assertion macro header
`include "crc_checked_telemetry_frame_parser_top_macros.svh"

module ctfp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  ctfp_pkg::t_frame_rec  i_rec,
    output logic                  o_q_pop,
    input  logic [7:0]            i_expected_version,
    input  logic                  i_pop,
    output logic                  o_valid,
    output ctfp_pkg::t_result     o_res
);
    import ctfp_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res, n_res;

    assign o_q_pop = i_q_valid && (!r_valid || i_pop);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_res = '0;
        if (i_rec.version != i_expected_version) begin
            n_res.status = ST_BAD_VERSION;
        end else if (i_rec.length != 8'(FRAME_BYTES)) begin
            n_res.status = ST_BAD_LENGTH;
        end else if (!i_rec.crc_ok) begin
            n_res.status = ST_BAD_CRC;
        end else begin
            n_res.status = ST_VALID;
        end
        // measurement fields only for a good frame
        if (n_res.status == ST_VALID) begin
            n_res.sequence_number    = {i_rec.body[1], i_rec.body[0]};
            n_res.timestamp_millis   = {i_rec.body[5], i_rec.body[4],
                                        i_rec.body[3], i_rec.body[2]};
            n_res.motion_mode        = i_rec.body[6];
            n_res.status_flags       = i_rec.body[7];
            n_res.track_acceleration = {i_rec.body[9], i_rec.body[8]};
            n_res.yaw_rate           = {i_rec.body[11], i_rec.body[10]};
            n_res.vibration_level    = {i_rec.body[13], i_rec.body[12]};
            n_res.line_offset        = {i_rec.body[15], i_rec.body[14]};
            n_res.left_wheel_speed   = {i_rec.body[17], i_rec.body[16]};
            n_res.right_wheel_speed  = {i_rec.body[19], i_rec.body[18]};
            n_res.turn_amount        = {i_rec.body[21], i_rec.body[20]};
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (o_q_pop) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= n_res;
        end
    end

    `CTFP_ASSERT(a_bad_zero,
        (r_valid && r_res.status != ST_VALID) |-> (r_res.timestamp_millis == '0),
        "fields of a bad frame not cleared")
    `CTFP_ASSERT_NEXT(a_load, i_q_valid && !r_valid, r_valid, "waiting record not loaded")

endmodule

FILE: rtl/core/crc_checked_telemetry_frame_parser_top.sv
// top level of the crc checked telemetry frame parser
// depends on ctfp_pkg, ctfp_front, ctfp_queue, ctfp_back
`include "crc_checked_telemetry_frame_parser_top_macros.svh"

// One received byte enters per transaction on the push/full side; while full is low one byte
// can be taken every clock cycle: the header hunt, frame store write and crc-16/ccitt-false
// update all finish in the cycle of the byte. A frame is 28 bytes in total, the two header
// bytes included; at the last byte a record is pushed into a two-entry queue, from which it
// moves into the output register and then shows on the output ports (empty low). The output
// register plus the queue hold three finished results; full rises only while all three wait
// to be popped, and it then holds off every byte until a result is taken. Results carry a
// status (0 valid, 1 bad version, 2 bad length byte, 3 bad crc, checked in that order) and
// the little-endian measurement fields, which are zero unless the status is valid.
// Configuration: cfg index 0 first header byte, 1 second header byte, 2 expected version;
// index 3 is ignored. Write only while no frame is in progress or waiting. No clearing
// pass after reset: the block takes bytes from the first cycle out of reset.

module crc_checked_telemetry_frame_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_rx_byte,
    // result output
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_frame_status,
    output logic [15:0]        o_sequence_number,
    output logic [31:0]        o_timestamp_millis,
    output logic [7:0]         o_motion_mode,
    output logic [7:0]         o_status_flags,
    output logic signed [15:0] o_track_acceleration,
    output logic signed [15:0] o_yaw_rate,
    output logic [15:0]        o_vibration_level,
    output logic signed [15:0] o_line_offset,
    output logic signed [15:0] o_left_wheel_speed,
    output logic signed [15:0] o_right_wheel_speed,
    output logic signed [15:0] o_turn_amount,
    // configuration write
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [7:0]         i_cfg_data
);
    import ctfp_pkg::*;

    // configuration registers
    logic [7:0] r_hdr_first;
    logic [7:0] r_hdr_second;
    logic [7:0] r_version;

    logic       byte_accept;
    logic       rec_push;
    t_frame_rec front_rec;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    t_frame_rec q_rec;
    logic       res_valid;
    t_result    res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= '0;
            r_hdr_second <= '0;
            r_version    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_HDR_FIRST:  r_hdr_first  <= i_cfg_data;
                CFG_HDR_SECOND: r_hdr_second <= i_cfg_data;
                CFG_VERSION:    r_version    <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // a full queue stalls every byte, so the frame end push never drops
    assign full        = q_full;
    assign byte_accept = push && !q_full;

    ctfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (byte_accept),
        .i_byte       (i_rx_byte),
        .i_hdr_first  (r_hdr_first),
        .i_hdr_second (r_hdr_second),
        .o_push       (rec_push),
        .o_rec        (front_rec)
    );

    ctfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    ctfp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_rec              (q_rec),
        .o_q_pop            (q_pop),
        .i_expected_version (r_version),
        .i_pop              (pop),
        .o_valid            (res_valid),
        .o_res              (res)
    );

    assign empty                = !res_valid;
    assign o_frame_status       = res.status;
    assign o_sequence_number    = res.sequence_number;
    assign o_timestamp_millis   = res.timestamp_millis;
    assign o_motion_mode        = res.motion_mode;
    assign o_status_flags       = res.status_flags;
    assign o_track_acceleration = res.track_acceleration;
    assign o_yaw_rate           = res.yaw_rate;
    assign o_vibration_level    = res.vibration_level;
    assign o_line_offset        = res.line_offset;
    assign o_left_wheel_speed   = res.left_wheel_speed;
    assign o_right_wheel_speed  = res.right_wheel_speed;
    assign o_turn_amount        = res.turn_amount;

endmodule
